FILE: rtl/lr_pkg.sv
// Shared types and constants for the line rasterizer.
// Holds the opcode and register index codes, reset values and the result record.
// No dependencies.
`timescale 1ns / 1ps

package lr_pkg;

  // Request opcodes.
  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam int CfgDataWidth = 15;

  localparam logic [CfgDataWidth-1:0] FRAME_WIDTH_RST  = 15'd1024;
  localparam logic [CfgDataWidth-1:0] FRAME_HEIGHT_RST = 15'd768;

  // One emitted pixel as it sits in the output register.
  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [31:0]        pixel_color;
    logic               in_frame;
    logic               last_pixel;
  } pix_t;

endpackage

FILE: rtl/line_rasterizer.sv
// Bresenham line rasterizer top level.
// Depends on lr_pkg for opcodes, register indexes and the pixel record.
`timescale 1ns / 1ps

// Usage:
// A start request (opcode OP_START) loads two signed endpoints and a color,
// sets up deltas, step directions and the error term, and emits the first
// pixel. Each step request (opcode OP_STEP) advances one pixel and emits it.
// A step request with no line in progress is consumed and emits nothing.
// Each pixel carries its coordinates, the color, an in-frame flag against
// frame_width/frame_height, and a last flag at the end point, which also
// ends the line.
// Channels use valid/stall; a request moves on a clock edge with valid high
// and stall low. The config port writes frame_width (index 0) or
// frame_height (index 1) whenever cfg_we is high.
// An accepted request's pixel is registered in the output or skid entry.
// One request is taken every cycle while in_stall is low: the whole setup or
// step update is one add/compare pass from line state to output register.
// A two-entry output (register plus skid) lets a request be taken while a
// pixel waits; in_stall rises only when both entries are full.
// Synchronous reset drops any line, empties the output and restores the
// frame size to 1024 x 768.
module line_rasterizer #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [14:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     opcode,
  input  logic signed [15:0]       start_x,
  input  logic signed [15:0]       start_y,
  input  logic signed [15:0]       end_x,
  input  logic signed [15:0]       end_y,
  input  logic [31:0]              line_color,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [15:0]       pixel_x,
  output logic signed [15:0]       pixel_y,
  output logic [31:0]              pixel_color,
  output logic                     in_frame,
  output logic                     last_pixel
);

  localparam int W    = COORD_WIDTH;
  localparam int EXTW = (W > 16) ? W : 16;
  localparam int ERRW = W + 2;
  localparam int E2W  = W + 3;
  localparam int CMPW = (W > 15) ? W : 15;

  // Sign-extend a 16-bit port coordinate and wrap it to W bits.
  function automatic logic signed [W-1:0] wrap_in(input logic signed [15:0] v);
    logic signed [EXTW-1:0] e;
    e = EXTW'(v);
    return e[W-1:0];
  endfunction

  // Low 16 bits of a W-bit coordinate, sign-extended when W is narrower.
  function automatic logic signed [15:0] to_port(input logic signed [W-1:0] c);
    logic signed [EXTW-1:0] e;
    e = EXTW'(c);
    return e[15:0];
  endfunction

  // True when 0 <= c < lim.
  function automatic logic below(input logic signed [W-1:0] c,
                                 input logic [14:0] lim);
    logic [CMPW-1:0] cu;
    logic [CMPW-1:0] lu;
    cu = CMPW'(c[W-2:0]);
    lu = CMPW'(lim);
    return !c[W-1] && (cu < lu);
  endfunction

  // Configuration registers.
  logic [14:0] frame_width;
  logic [14:0] frame_height;

  // Line state.
  logic signed [W-1:0]    cur_x, cur_y, target_x, target_y;
  logic [W-1:0]           delta_x, delta_y;
  logic                   step_x_neg, step_y_neg;
  logic signed [ERRW-1:0] error_term;
  logic [31:0]            held_color;
  logic                   line_active;

  // Output register and skid entry.
  lr_pkg::pix_t out_res, skid_res, res;
  logic         skid_valid;

  logic accept, is_start, produce, out_fire;

  // Setup terms for a start request.
  logic signed [W-1:0]    x0, y0, x1, y1;
  logic signed [W:0]      dx_s, dy_s;
  logic [W-1:0]           adx, ady;
  logic signed [ERRW-1:0] err_init;
  logic                   sx_neg, sy_neg;

  // Step terms.
  logic signed [E2W-1:0]  e2, ndy, pdx, err_sum;
  logic                   take_x, take_y;
  logic signed [W-1:0]    nx, ny;
  logic signed [ERRW-1:0] err_step;

  // Values after this request.
  logic signed [W-1:0]    new_x, new_y, new_tx, new_ty;
  logic [31:0]            new_color;
  logic                   new_last;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign is_start = (opcode == lr_pkg::OP_START);
  assign produce  = accept && (is_start || line_active);
  assign out_fire = out_valid && !out_stall;

  // Line setup: wrapped endpoints, absolute deltas, directions, error term.
  always_comb begin
    x0       = wrap_in(start_x);
    y0       = wrap_in(start_y);
    x1       = wrap_in(end_x);
    y1       = wrap_in(end_y);
    dx_s     = $signed({x1[W-1], x1}) - $signed({x0[W-1], x0});
    dy_s     = $signed({y1[W-1], y1}) - $signed({y0[W-1], y0});
    adx      = dx_s[W] ? W'(-dx_s) : dx_s[W-1:0];
    ady      = dy_s[W] ? W'(-dy_s) : dy_s[W-1:0];
    err_init = $signed(ERRW'(adx)) - $signed(ERRW'(ady));
    sx_neg   = !(x0 < x1);
    sy_neg   = !(y0 < y1);
  end

  // One Bresenham step with the two-sided test on twice the error.
  always_comb begin
    e2      = $signed({error_term, 1'b0});
    ndy     = -$signed(E2W'(delta_y));
    pdx     = $signed(E2W'(delta_x));
    take_x  = e2 > ndy;
    take_y  = e2 < pdx;
    err_sum = E2W'(error_term) + (take_x ? ndy : E2W'(0)) + (take_y ? pdx : E2W'(0));
    err_step = err_sum[ERRW-1:0];
    nx = take_x ? (step_x_neg ? cur_x - W'(1) : cur_x + W'(1)) : cur_x;
    ny = take_y ? (step_y_neg ? cur_y - W'(1) : cur_y + W'(1)) : cur_y;
  end

  // Pixel for this request.
  always_comb begin
    new_x     = is_start ? x0 : nx;
    new_y     = is_start ? y0 : ny;
    new_tx    = is_start ? x1 : target_x;
    new_ty    = is_start ? y1 : target_y;
    new_color = is_start ? line_color : held_color;
    new_last  = (new_x == new_tx) && (new_y == new_ty);
    res.pixel_x     = to_port(new_x);
    res.pixel_y     = to_port(new_y);
    res.pixel_color = new_color;
    res.in_frame    = below(new_x, frame_width) && below(new_y, frame_height);
    res.last_pixel  = new_last;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lr_pkg::FRAME_WIDTH_RST;
      frame_height <= lr_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (lr_pkg::cfg_reg_t'(cfg_index))
        lr_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        lr_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  // Line state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      target_x    <= '0;
      target_y    <= '0;
      delta_x     <= '0;
      delta_y     <= '0;
      step_x_neg  <= 1'b0;
      step_y_neg  <= 1'b0;
      error_term  <= '0;
      held_color  <= '0;
      line_active <= 1'b0;
    end else if (produce) begin
      cur_x       <= new_x;
      cur_y       <= new_y;
      line_active <= !new_last;
      if (is_start) begin
        target_x   <= x1;
        target_y   <= y1;
        delta_x    <= adx;
        delta_y    <= ady;
        step_x_neg <= sx_neg;
        step_y_neg <= sy_neg;
        error_term <= err_init;
        held_color <= line_color;
      end else begin
        error_term <= err_step;
      end
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (produce) begin
      if (!out_valid || out_fire) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign pixel_x     = out_res.pixel_x;
  assign pixel_y     = out_res.pixel_y;
  assign pixel_color = out_res.pixel_color;
  assign in_frame    = out_res.in_frame;
  assign last_pixel  = out_res.last_pixel;

  // The skid entry is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a pixel while the output register is empty");

  // An emitted end point leaves no line in progress.
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (produce && new_last) |=> !line_active)
    else $error("line still active after its end point");

  // A step request with no line in progress creates no pixel.
  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_start && !line_active && !out_valid) |=> !out_valid)
    else $error("pixel emitted for a step with no line in progress");

  // A step moves x by at most one.
  a_step_small: assert property (@(posedge clk) disable iff (rst)
    (produce && !is_start) |->
      ((nx == cur_x) || (nx == cur_x + W'(1)) || (nx == cur_x - W'(1))))
    else $error("step moved x by more than one pixel");

endmodule
